>>> design/dgrs_pkg.sv
// Shared types, constants and helper functions of the DDA grid ray stepper.
`default_nettype none
package dgrs_pkg;

  // Fixed field widths of the request and result channels.
  localparam int POS_W  = 24;
  localparam int DIR_W  = 18;
  localparam int CELL_W = 10;
  localparam int DIST_W = 32;

  localparam logic signed [CELL_W-1:0] CELL_MAX = 10'sd511;
  localparam logic signed [CELL_W-1:0] CELL_MIN = -10'sd512;

  // Request command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Axis codes, also used for the crossed side.
  localparam logic AX_X = 1'b0;
  localparam logic AX_Y = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_AXIS,
    S_STEP
  } dgrs_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic div_init;
    logic div_step;
    logic mul_en;
    logic axis_wr;
    logic axis;
    logic do_step;
    logic emit;
  } dgrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
    logic out_free;
  } dgrs_stat_t;

  // Unsigned 32-bit add that saturates at all ones.
  function automatic logic [DIST_W-1:0] sat_add32(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
    logic [DIST_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DIST_W] ? {DIST_W{1'b1}} : sum[DIST_W-1:0];
  endfunction

  // Move a cell one unit up or down, saturating at the cell range ends.
  function automatic logic signed [CELL_W-1:0] cell_step(input logic signed [CELL_W-1:0] c,
                                                         input logic neg);
    logic signed [CELL_W:0] ext;
    ext = {c[CELL_W-1], c} + (neg ? -11'sd1 : 11'sd1);
    if (ext > 11'sd511) begin
      return CELL_MAX;
    end else if (ext < -11'sd512) begin
      return CELL_MIN;
    end
    return ext[CELL_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> design/dgrs_ctrl.sv
// Controller state machine that sequences ray setup and cell steps.
`default_nettype none
module dgrs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_cmd,
  output dgrs_pkg::dgrs_cmd_t    cmd,
  input  wire dgrs_pkg::dgrs_stat_t stat
);
  import dgrs_pkg::*;

  dgrs_state_t state_r, state_nxt;
  logic        axis_r, axis_nxt;

  // State and axis registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= AX_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch    = 1'b1;
          cmd.div_init = 1'b1;
          axis_nxt     = AX_X;
          state_nxt    = (in_cmd == CMD_STEP) ? S_STEP : S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_AXIS;
      end
      S_AXIS: begin
        if (axis_r == AX_X) begin
          cmd.axis_wr  = 1'b1;
          cmd.div_init = 1'b1;
          axis_nxt     = AX_Y;
          state_nxt    = S_DIV;
        end else if (stat.out_free) begin
          cmd.axis_wr = 1'b1;
          cmd.emit    = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_STEP: begin
        if (stat.out_free) begin
          cmd.do_step = 1'b1;
          cmd.emit    = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("controller stayed idle after accepting a request");

  // The multiply state is always followed by the axis write-back state.
  a_mul_then_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> (state_r == S_AXIS))
    else $error("multiply not followed by axis write");

  // A result is sent only after a step or after the y axis of a setup.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> ((state_r == S_STEP) || (state_r == S_AXIS && axis_r == AX_Y)))
    else $error("result sent from an unexpected state");
`endif

endmodule
`default_nettype wire

>>> design/dgrs_dpath.sv
// Datapath: ray state, shared reciprocal divider, side multiplier and result register.
`default_nettype none
module dgrs_dpath #(
  parameter int MAP_BITS  = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire dgrs_pkg::dgrs_cmd_t                   cmd,
  output dgrs_pkg::dgrs_stat_t                       stat,
  input  wire logic [dgrs_pkg::POS_W-1:0]            in_pos_x,
  input  wire logic [dgrs_pkg::POS_W-1:0]            in_pos_y,
  input  wire logic signed [dgrs_pkg::DIR_W-1:0]     in_dir_x,
  input  wire logic signed [dgrs_pkg::DIR_W-1:0]     in_dir_y,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [dgrs_pkg::CELL_W-1:0]         out_cell_x,
  output logic signed [dgrs_pkg::CELL_W-1:0]         out_cell_y,
  output logic                                       out_crossed_side,
  output logic [dgrs_pkg::DIST_W-1:0]                out_dist_x,
  output logic [dgrs_pkg::DIST_W-1:0]                out_dist_y,
  output logic                                       out_out_of_map
);
  import dgrs_pkg::*;

  // Quotient bits of 2^(2F) / mag, counter width, distance and product widths.
  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(QW + 1);
  localparam int DW = FRAC_BITS + 1;
  localparam int PW = DW + DIST_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);
  localparam logic [POS_W:0] ONE_POS = {{POS_W{1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [CELL_W:0] MAP_LIM = (CELL_W+1)'(1 << MAP_BITS);

  // Latched request fields.
  logic [POS_W-1:0]        pos_x_r, pos_y_r;
  logic [DIR_W-1:0]        dir_x_r, dir_y_r;

  // Divider registers.
  logic [DIR_W-1:0]        rem_r;
  logic [DIST_W-1:0]       q_r;
  logic                    qovf_r;
  logic [CW-1:0]           cnt_r;
  logic [PW-1:0]           prod_r;

  // Ray state.
  logic signed [CELL_W-1:0] cell_x_r, cell_x_nxt, cell_y_r, cell_y_nxt;
  logic                     neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [DIST_W-1:0]        delta_x_r, delta_x_nxt, delta_y_r, delta_y_nxt;
  logic [DIST_W-1:0]        side_x_r, side_x_nxt, side_y_r, side_y_nxt;
  logic                     last_axis_r, last_axis_nxt;

  // Result register.
  logic                     out_valid_r;
  logic signed [CELL_W-1:0] out_cell_x_r, out_cell_y_r;
  logic                     out_side_r, out_map_r;
  logic [DIST_W-1:0]        out_dist_x_r, out_dist_y_r;

  // Operands of the axis that is being set up.
  logic [POS_W-1:0]        sel_pos;
  logic [DIR_W-1:0]        sel_dir;
  logic                    dir_neg;
  logic [DIR_W-1:0]        mag;
  logic [DIR_W:0]          rem_sh, rem_sub;
  logic                    q_bit;
  logic [DIR_W-1:0]        rem_nxt;
  logic [DIST_W-1:0]       delta_c;
  logic [POS_W:0]          frac_w, dist_w;
  logic [DW-1:0]           bnd_dist;
  logic [DIST_W:0]         side_raw;
  logic [DIST_W-1:0]       side_c;
  logic [POS_W-1:0]        ipart;
  logic signed [CELL_W-1:0] cell_c;
  logic                    go_x;
  logic                    map_off;

  assign sel_pos = (cmd.axis == AX_Y) ? pos_y_r : pos_x_r;
  assign sel_dir = (cmd.axis == AX_Y) ? dir_y_r : dir_x_r;
  assign dir_neg = sel_dir[DIR_W-1];
  assign mag     = dir_neg ? (DIR_W'(0) - sel_dir) : sel_dir;

  // One restoring division step; the dividend is a single one at its top bit.
  assign rem_sh  = {rem_r, (cnt_r == '0)};
  assign rem_sub = rem_sh - {1'b0, mag};
  assign q_bit   = (rem_sh >= {1'b0, mag});
  assign rem_nxt = q_bit ? rem_sub[DIR_W-1:0] : rem_sh[DIR_W-1:0];

  // Delta saturates for a zero direction or a quotient beyond 32 bits.
  assign delta_c = ((mag == '0) || qovf_r) ? {DIST_W{1'b1}} : q_r;

  // Distance from the position to the first boundary, in fraction units.
  assign frac_w   = {1'b0, sel_pos} & (ONE_POS - 1'b1);
  assign dist_w   = dir_neg ? frac_w : (ONE_POS - frac_w);
  assign bnd_dist = dist_w[DW-1:0];

  // Scaled product and its saturation.
  assign side_raw = prod_r[PW-1:FRAC_BITS];
  assign side_c   = side_raw[DIST_W] ? {DIST_W{1'b1}} : side_raw[DIST_W-1:0];

  // Starting cell, saturated at the top of the cell range.
  assign ipart  = sel_pos >> FRAC_BITS;
  assign cell_c = (ipart > POS_W'(CELL_MAX)) ? CELL_MAX : ipart[CELL_W-1:0];

  assign go_x = (side_x_r < side_y_r);

  // Next ray state for an axis setup or a cell step.
  always_comb begin
    cell_x_nxt    = cell_x_r;
    cell_y_nxt    = cell_y_r;
    neg_x_nxt     = neg_x_r;
    neg_y_nxt     = neg_y_r;
    delta_x_nxt   = delta_x_r;
    delta_y_nxt   = delta_y_r;
    side_x_nxt    = side_x_r;
    side_y_nxt    = side_y_r;
    last_axis_nxt = last_axis_r;
    if (cmd.axis_wr) begin
      last_axis_nxt = AX_X;
      if (cmd.axis == AX_X) begin
        cell_x_nxt  = cell_c;
        neg_x_nxt   = dir_neg;
        delta_x_nxt = delta_c;
        side_x_nxt  = side_c;
      end else begin
        cell_y_nxt  = cell_c;
        neg_y_nxt   = dir_neg;
        delta_y_nxt = delta_c;
        side_y_nxt  = side_c;
      end
    end else if (cmd.do_step) begin
      if (go_x) begin
        side_x_nxt    = sat_add32(side_x_r, delta_x_r);
        cell_x_nxt    = cell_step(cell_x_r, neg_x_r);
        last_axis_nxt = AX_X;
      end else begin
        side_y_nxt    = sat_add32(side_y_r, delta_y_r);
        cell_y_nxt    = cell_step(cell_y_r, neg_y_r);
        last_axis_nxt = AX_Y;
      end
    end
  end

  // Map bounds test on the updated cell.
  assign map_off = cell_x_nxt[CELL_W-1] || cell_y_nxt[CELL_W-1] ||
                   ({cell_x_nxt[CELL_W-1], cell_x_nxt} >= MAP_LIM) ||
                   ({cell_y_nxt[CELL_W-1], cell_y_nxt} >= MAP_LIM);

  // Request field capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      dir_x_r <= in_dir_x;
      dir_y_r <= in_dir_y;
    end
  end

  // Reciprocal divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_init) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= '0;
      q_r    <= '0;
      qovf_r <= 1'b0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      q_r    <= {q_r[DIST_W-2:0], q_bit};
      qovf_r <= qovf_r | q_r[DIST_W-1];
    end
  end

  // Side distance multiplier.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= {{DIST_W{1'b0}}, bnd_dist} * {{DW{1'b0}}, delta_c};
    end
  end

  // Ray state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_x_r    <= '0;
      cell_y_r    <= '0;
      neg_x_r     <= 1'b0;
      neg_y_r     <= 1'b0;
      delta_x_r   <= '0;
      delta_y_r   <= '0;
      side_x_r    <= '0;
      side_y_r    <= '0;
      last_axis_r <= AX_X;
    end else begin
      cell_x_r    <= cell_x_nxt;
      cell_y_r    <= cell_y_nxt;
      neg_x_r     <= neg_x_nxt;
      neg_y_r     <= neg_y_nxt;
      delta_x_r   <= delta_x_nxt;
      delta_y_r   <= delta_y_nxt;
      side_x_r    <= side_x_nxt;
      side_y_r    <= side_y_nxt;
      last_axis_r <= last_axis_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_cell_x_r <= cell_x_nxt;
      out_cell_y_r <= cell_y_nxt;
      out_side_r   <= last_axis_nxt;
      out_dist_x_r <= side_x_nxt;
      out_dist_y_r <= side_y_nxt;
      out_map_r    <= map_off;
    end
  end

  assign stat.div_last = (cnt_r == CNT_LAST);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_cell_x       = out_cell_x_r;
  assign out_cell_y       = out_cell_y_r;
  assign out_crossed_side = out_side_r;
  assign out_dist_x       = out_dist_x_r;
  assign out_dist_y       = out_dist_y_r;
  assign out_out_of_map   = out_map_r;

`ifndef ASSERT_OFF
  // A result is only loaded when the result register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result loaded over an unread result");

  // A loaded result is offered on the next cycle.
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("loaded result not offered");

  // A cell step advances at most one side distance.
  a_step_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_step |=> ($stable(side_x_r) || $stable(side_y_r)))
    else $error("cell step changed both side distances");
`endif

endmodule
`default_nettype wire

>>> design/dda_grid_ray_stepper.sv
// Top level of the DDA grid ray stepper: controller plus datapath.
//
// Usage: requests arrive on the in_ channel (valid/ready). A request with
// in_cmd = 0 starts a ray from in_pos_x/in_pos_y and in_dir_x/in_dir_y; a
// request with in_cmd = 1 advances the ray one cell. Each request yields one
// result on the out_ channel (valid/ready): the cell, the crossed axis, both
// side distances and the off-map flag after the update.
// Sequencing: a step result is loaded into the result register as soon as
// that register is free, and the next request is taken once the controller
// is back in idle. A start request runs two reciprocals of 2*FRAC_BITS+1
// quotient bits each through one shared bit-serial divider, then one
// multiply and one write-back per axis, x first, then y; its result is
// loaded once the y write-back finds the result register free. The block
// works on one request at a time; in_ready is high only while idle.
// Reset clears the ray state to zero, empties the result register and
// returns the controller to idle; a step before any start works on that state.
// When the receiver stalls, the result waits in the output register; the block
// still accepts one more request but holds its result until the register frees.
`default_nettype none
module dda_grid_ray_stepper #(
  parameter int MAP_BITS  = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_cmd,
  input  wire logic [dgrs_pkg::POS_W-1:0]            in_pos_x,
  input  wire logic [dgrs_pkg::POS_W-1:0]            in_pos_y,
  input  wire logic signed [dgrs_pkg::DIR_W-1:0]     in_dir_x,
  input  wire logic signed [dgrs_pkg::DIR_W-1:0]     in_dir_y,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [dgrs_pkg::CELL_W-1:0]         out_cell_x,
  output logic signed [dgrs_pkg::CELL_W-1:0]         out_cell_y,
  output logic                                       out_crossed_side,
  output logic [dgrs_pkg::DIST_W-1:0]                out_dist_x,
  output logic [dgrs_pkg::DIST_W-1:0]                out_dist_y,
  output logic                                       out_out_of_map
);
  import dgrs_pkg::*;

  dgrs_cmd_t  cmd;
  dgrs_stat_t stat;

  // Sequencer for setup and step requests.
  dgrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Ray state, arithmetic and result register.
  dgrs_dpath #(
    .MAP_BITS  (MAP_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_dir_x         (in_dir_x),
    .in_dir_y         (in_dir_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_x       (out_cell_x),
    .out_cell_y       (out_cell_y),
    .out_crossed_side (out_crossed_side),
    .out_dist_x       (out_dist_x),
    .out_dist_y       (out_dist_y),
    .out_out_of_map   (out_out_of_map)
  );

endmodule
`default_nettype wire
